// ===== src/cpba_pkg.sv =====
// ----------------------------------------------------------------------------
// cpba_pkg
// Shared types and constants for the contiguous page bitmap allocator.
// ----------------------------------------------------------------------------
package cpba_pkg;

    // default map size in pages
    localparam int MAP_PAGES_DEF = 1024;

    // bitmap word geometry
    localparam int WORD_BITS = 32;
    localparam int WORD_SH   = 5;

    // beat field widths
    localparam int START_W  = 10;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 2;
    localparam int BASE_W   = 10;

    // request modes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // result codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_ROOM  = 2'd1,
        ST_BAD_FREE = 2'd2,
        ST_ZERO     = 2'd3
    } status_t;

    // control sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_CHECK,
        S_MARK,
        S_DONE
    } state_t;

endpackage

// ===== src/cpba_map_ram.sv =====
// ----------------------------------------------------------------------------
// cpba_map_ram
// Bitmap word store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cpba_map_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                           clk,
    input  logic                           we,
    input  logic [AW-1:0]                  waddr,
    input  logic [cpba_pkg::WORD_BITS-1:0] wdata,
    input  logic                           re,
    input  logic [AW-1:0]                  raddr,
    output logic [cpba_pkg::WORD_BITS-1:0] rdata
);
    import cpba_pkg::*;

    logic [WORD_BITS-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/contiguous_page_bitmap_allocator_top.sv =====
// Allocate scans bitmap words until a run is found, then reads and marks the words that
//   the run spans. Free reads the words of its range to check them, then reads and marks
//   them; a zero count or a range past the map goes straight to the result.
// Throughput: one request at a time, bounded by the single bitmap read port (one word a cycle).
// Reset: a clearing pass writes every bitmap word; req_stall stays high until it is done.
// ----------------------------------------------------------------------------
// contiguous_page_bitmap_allocator_top
// First-fit allocator over a used/free page bitmap held in a word memory.
// ----------------------------------------------------------------------------
module contiguous_page_bitmap_allocator_top #(
    parameter int MAP_PAGES = cpba_pkg::MAP_PAGES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic                          mode,
    input  logic [cpba_pkg::START_W-1:0]  start_page,
    input  logic [cpba_pkg::COUNT_W-1:0]  page_count,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [cpba_pkg::STATUS_W-1:0] status,
    output logic [cpba_pkg::BASE_W-1:0]   base_page
);
    import cpba_pkg::*;

    localparam int MAP_WORDS = (MAP_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int PAGE_W    = $clog2(MAP_PAGES + 1);
    localparam int CW        = ((PAGE_W > COUNT_W) ? PAGE_W : COUNT_W) + 2;
    localparam int PAD_BITS  = MAP_PAGES % WORD_BITS;
    localparam logic [WORD_BITS-1:0] PAD_MASK =
        (PAD_BITS == 0) ? '0 : ({WORD_BITS{1'b1}} << PAD_BITS);
    localparam logic [WORD_AW-1:0] LAST_WORD   = WORD_AW'(MAP_WORDS - 1);
    localparam logic [CW-1:0]      MAP_PAGES_C = CW'(MAP_PAGES);
    localparam logic [CW-1:0]      WORD_BITS_C = CW'(WORD_BITS);

    // control registers
    state_t               state_reg, state_next;
    logic [WORD_AW-1:0]   k_reg, k_next;
    logic                 iss_done_reg, iss_done_next;
    logic                 rd_valid_reg, rd_valid_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    // payload registers
    logic [WORD_AW-1:0]   proc_idx_reg, proc_idx_next;
    logic                 mode_reg, mode_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [CW-1:0]        lo_reg, lo_next;
    logic [CW-1:0]        hi_reg, hi_next;
    logic [CW-1:0]        run_reg, run_next;
    logic [CW-1:0]        run_start_reg, run_start_next;
    status_t              res_status_reg, res_status_next;
    logic [CW-1:0]        res_base_reg, res_base_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [BASE_W-1:0]    base_reg, base_next;

    // memory port signals
    logic                 mem_we;
    logic [WORD_AW-1:0]   mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [WORD_BITS-1:0] mem_rdata;

    // word search signals
    logic [WORD_BITS-1:0]      free_bits;
    logic [5:0][WORD_BITS-1:0] win_g;
    logic [5:0]                tz;
    logic [5:0]                lz;
    logic [2:0]                lg;
    logic [4:0]                sh_full;
    logic [3:0]                sh;
    logic [WORD_BITS-1:0]      win;
    logic [4:0]                pos;
    logic                      carry_hit;
    logic                      found;
    logic [CW-1:0]             base_w;
    logic [CW-1:0]             start_eff;
    logic [CW-1:0]             found_base;
    logic [CW-1:0]             run_new;
    logic [CW-1:0]             run_start_new;

    // range mask signals
    logic [WORD_AW-1:0]   fw;
    logic [WORD_AW-1:0]   lw;
    logic [4:0]           lo_bit;
    logic [4:0]           hi_bit;
    logic [WORD_BITS-1:0] rng_mask;
    logic                 check_fail;
    logic [WORD_BITS-1:0] init_word;
    logic [CW-1:0]        end_sum;
    logic [CW-1:0]        req_lo;

    cpba_map_ram #(
        .DEPTH (MAP_WORDS),
        .AW    (WORD_AW)
    ) u_map_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (k_reg),
        .rdata (mem_rdata)
    );

    // first-fit search inside one returned word
    always_comb
    begin
        free_bits = ~mem_rdata;
        tz = 6'd32;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (mem_rdata[i])
            begin
                tz = 6'(i);
            end
        end
        lz = 6'd32;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (mem_rdata[i])
            begin
                lz = 6'(WORD_BITS - 1 - i);
            end
        end
        // windows of 2^k free bits starting at each position
        win_g[0] = free_bits;
        for (int k = 1; k < 6; k++)
        begin
            win_g[k] = win_g[k-1] & (win_g[k-1] >> (1 << (k - 1)));
        end
        priority if (count_reg[5]) lg = 3'd5;
        else if (count_reg[4])     lg = 3'd4;
        else if (count_reg[3])     lg = 3'd3;
        else if (count_reg[2])     lg = 3'd2;
        else if (count_reg[1])     lg = 3'd1;
        else                       lg = 3'd0;
        sh_full = count_reg[4:0] ^ (5'd1 << lg);
        sh = sh_full[3:0];
        // two overlapping power-of-two windows cover a window of count bits
        if (count_reg <= COUNT_W'(WORD_BITS))
        begin
            win = win_g[lg] & (win_g[lg] >> sh);
        end
        else
        begin
            win = '0;
        end
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (win[i])
            begin
                pos = 5'(i);
            end
        end
        base_w     = CW'({proc_idx_reg, 5'b0});
        start_eff  = (run_reg == '0) ? base_w : run_start_reg;
        carry_hit  = (run_reg + CW'(tz)) >= CW'(count_reg);
        found      = rd_valid_reg && (carry_hit || (win != '0));
        found_base = carry_hit ? start_eff : (base_w + CW'(pos));
        // free run carried into the next word
        if (mem_rdata == '0)
        begin
            run_new       = run_reg + WORD_BITS_C;
            run_start_new = start_eff;
        end
        else
        begin
            run_new       = CW'(lz);
            run_start_new = base_w + CW'(6'd32 - lz);
        end
    end

    // page range mask for the word being processed
    always_comb
    begin
        fw = WORD_AW'(lo_reg >> WORD_SH);
        lw = WORD_AW'(hi_reg >> WORD_SH);
        lo_bit = (proc_idx_reg == fw) ? lo_reg[4:0] : 5'd0;
        hi_bit = (proc_idx_reg == lw) ? hi_reg[4:0] : 5'd31;
        rng_mask = ({WORD_BITS{1'b1}} << lo_bit) & ({WORD_BITS{1'b1}} >> (5'd31 - hi_bit));
        check_fail = (mem_rdata & rng_mask) != rng_mask;
        init_word = ((k_reg == '0) ? WORD_BITS'(1) : '0)
                  | ((k_reg == LAST_WORD) ? PAD_MASK : '0);
        req_lo  = CW'(start_page);
        end_sum = req_lo + CW'(page_count);
    end

    // next state, memory control and result
    always_comb
    begin
        state_next      = state_reg;
        k_next          = k_reg;
        iss_done_next   = iss_done_reg;
        proc_idx_next   = proc_idx_reg;
        mode_next       = mode_reg;
        count_next      = count_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        run_next        = run_reg;
        run_start_next  = run_start_reg;
        res_status_next = res_status_reg;
        res_base_next   = res_base_reg;
        status_next     = status_reg;
        base_next       = base_reg;
        rsp_valid_next  = rsp_valid_reg;
        mem_we          = 1'b0;
        mem_waddr       = proc_idx_reg;
        mem_wdata       = mem_rdata;
        mem_re          = 1'b0;
        req_stall       = (state_reg != S_IDLE);

        // result beat taken
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        // streaming word reads
        if ((state_reg == S_SCAN || state_reg == S_CHECK || state_reg == S_MARK)
            && !iss_done_reg
            && !(state_reg == S_SCAN && found)
            && !(state_reg == S_CHECK && rd_valid_reg && check_fail))
        begin
            mem_re        = 1'b1;
            proc_idx_next = k_reg;
            k_next        = k_reg + 1'b1;
            if ((state_reg == S_SCAN && k_reg == LAST_WORD)
                || (state_reg != S_SCAN && k_reg == lw))
            begin
                iss_done_next = 1'b1;
            end
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = k_reg;
                mem_wdata = init_word;
                k_next    = k_reg + 1'b1;
                if (k_reg == LAST_WORD)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    mode_next     = mode;
                    count_next    = page_count;
                    lo_next       = req_lo;
                    hi_next       = end_sum - CW'(1);
                    res_base_next = '0;
                    iss_done_next = 1'b0;
                    run_next      = '0;
                    run_start_next = '0;
                    if (page_count == '0)
                    begin
                        res_status_next = ST_ZERO;
                        state_next      = S_DONE;
                    end
                    else if (mode == MODE_ALLOC)
                    begin
                        k_next     = '0;
                        state_next = S_SCAN;
                    end
                    else if (end_sum > MAP_PAGES_C)
                    begin
                        res_status_next = ST_BAD_FREE;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        k_next     = WORD_AW'(req_lo >> WORD_SH);
                        state_next = S_CHECK;
                    end
                end
            end
            S_SCAN:
            begin
                if (rd_valid_reg)
                begin
                    if (found)
                    begin
                        lo_next       = found_base;
                        hi_next       = found_base + CW'(count_reg) - CW'(1);
                        res_base_next = found_base;
                        k_next        = WORD_AW'(found_base >> WORD_SH);
                        iss_done_next = 1'b0;
                        state_next    = S_MARK;
                    end
                    else
                    begin
                        run_next       = run_new;
                        run_start_next = run_start_new;
                        if (proc_idx_reg == LAST_WORD)
                        begin
                            res_status_next = ST_NO_ROOM;
                            state_next      = S_DONE;
                        end
                    end
                end
            end
            S_CHECK:
            begin
                if (rd_valid_reg)
                begin
                    if (check_fail)
                    begin
                        res_status_next = ST_BAD_FREE;
                        state_next      = S_DONE;
                    end
                    else if (proc_idx_reg == lw)
                    begin
                        k_next        = fw;
                        iss_done_next = 1'b0;
                        state_next    = S_MARK;
                    end
                end
            end
            S_MARK:
            begin
                if (rd_valid_reg)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = (mode_reg == MODE_FREE) ? (mem_rdata & ~rng_mask)
                                                        : (mem_rdata | rng_mask);
                    if (proc_idx_reg == lw)
                    begin
                        res_status_next = ST_OK;
                        state_next      = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    base_next      = (res_status_reg == ST_OK) ? res_base_reg[BASE_W-1:0] : '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            k_reg         <= '0;
            iss_done_reg  <= 1'b0;
            rd_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            iss_done_reg  <= iss_done_next;
            rd_valid_reg  <= rd_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rd_valid_next = mem_re;

    // payload state
    always_ff @(posedge clk)
    begin
        proc_idx_reg   <= proc_idx_next;
        mode_reg       <= mode_next;
        count_reg      <= count_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        run_reg        <= run_next;
        run_start_reg  <= run_start_next;
        res_status_reg <= res_status_next;
        res_base_reg   <= res_base_next;
        status_reg     <= status_next;
        base_reg       <= base_next;
    end

    // result beat
    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign base_page = base_reg;

endmodule

// ===== src/cpba_checker.sv =====
// ----------------------------------------------------------------------------
// cpba_checker
// Port-level checks on the allocator's request and result beats.
// ----------------------------------------------------------------------------
module cpba_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_stall,
    input logic                          mode,
    input logic [cpba_pkg::START_W-1:0]  start_page,
    input logic [cpba_pkg::COUNT_W-1:0]  page_count,
    input logic                          rsp_valid,
    input logic                          rsp_stall,
    input logic [cpba_pkg::STATUS_W-1:0] status,
    input logic [cpba_pkg::BASE_W-1:0]   base_page
);
    import cpba_pkg::*;

    // stalled result beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(base_page))
        else $error("result beat changed while stalled");

    // base page is zero on every error
    a_base_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != ST_OK) |-> base_page == '0)
        else $error("nonzero base page on error result");

    // one request at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted while busy");

    // results only come out of a busy block
    a_rsp_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("result beat without work in progress");

endmodule

bind contiguous_page_bitmap_allocator_top cpba_checker u_cpba_checker (.*);

// ===== dv/cpba_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cpba_result_checker
// Watches both channels of the page allocator. It keeps its own used/free
// page map, works out the status and base page of every accepted request
// and compares each accepted result beat against the oldest of those.
// ----------------------------------------------------------------------------
module cpba_result_checker #(
    parameter int MAP_PAGES = cpba_pkg::MAP_PAGES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_stall,
    input  logic                          mode,
    input  logic [cpba_pkg::START_W-1:0]  start_page,
    input  logic [cpba_pkg::COUNT_W-1:0]  page_count,
    input  logic                          rsp_valid,
    input  logic                          rsp_stall,
    input  logic [cpba_pkg::STATUS_W-1:0] status,
    input  logic [cpba_pkg::BASE_W-1:0]   base_page,
    output int                            error_count,
    output int                            pending_results
);
    import cpba_pkg::*;

    typedef struct packed {
        status_t             status;
        logic [BASE_W-1:0]   base;
    } outcome_t;

    // one bit per page, set while the page is allocated
    logic [MAP_PAGES-1:0] used_pages;
    outcome_t             awaited_outcomes[$];
    int                   mismatch_total = 0;

    // first-fit allocate or checked free against the local page map
    function automatic outcome_t apply_request(
        input logic               req_mode,
        input logic [START_W-1:0] first,
        input logic [COUNT_W-1:0] count
    );
        outcome_t res;
        int       pg;
        int       run_len;
        int       run_base;
        bit       found;
        bit       range_ok;
        res.status = ST_OK;
        res.base   = '0;
        if (count == '0)
        begin
            res.status = ST_ZERO;
        end
        else if (req_mode == MODE_ALLOC)
        begin
            run_len  = 0;
            run_base = 0;
            found    = 1'b0;
            for (pg = 0; pg < MAP_PAGES && !found; pg++)
            begin
                if (used_pages[pg])
                begin
                    run_len = 0;
                end
                else
                begin
                    if (run_len == 0)
                        run_base = pg;
                    run_len++;
                    if (run_len == int'(count))
                        found = 1'b1;
                end
            end
            if (found)
            begin
                for (pg = run_base; pg < run_base + int'(count); pg++)
                    used_pages[pg] = 1'b1;
                res.base = BASE_W'(run_base);
            end
            else
            begin
                res.status = ST_NO_ROOM;
            end
        end
        else
        begin
            // whole range must sit inside the map and be allocated
            range_ok = (int'(first) + int'(count)) <= MAP_PAGES;
            for (pg = int'(first); range_ok && pg < int'(first) + int'(count); pg++)
            begin
                if (!used_pages[pg])
                    range_ok = 1'b0;
            end
            if (range_ok)
            begin
                for (pg = int'(first); pg < int'(first) + int'(count); pg++)
                    used_pages[pg] = 1'b0;
            end
            else
            begin
                res.status = ST_BAD_FREE;
            end
        end
        return res;
    endfunction

    // results are retired before the request of the same edge is predicted
    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            used_pages     = '0;
            used_pages[0]  = 1'b1;
            awaited_outcomes.delete();
            mismatch_total = 0;
            error_count     <= 0;
            pending_results <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (awaited_outcomes.size() == 0)
                begin
                    $error("result beat with no request outstanding: status %0d base_page %0d",
                           status, base_page);
                    mismatch_total++;
                end
                else
                begin
                    want = awaited_outcomes.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d", want.status, status);
                        mismatch_total++;
                    end
                    if (base_page !== want.base)
                    begin
                        $error("base_page mismatch: expected %0d, actual %0d",
                               want.base, base_page);
                        mismatch_total++;
                    end
                end
            end
            if (req_valid && !req_stall)
                awaited_outcomes.push_back(apply_request(mode, start_page, page_count));
            error_count     <= mismatch_total;
            pending_results <= awaited_outcomes.size();
        end
    end

endmodule

// ===== dv/contiguous_page_bitmap_allocator_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// contiguous_page_bitmap_allocator_top_test
// Drives allocate and free requests into the page allocator: a directed
// opening over the corner cases, then random traffic built mostly from
// allocates and frees of runs the block really handed out, mixed with noise. Both sides
// idle at random and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module contiguous_page_bitmap_allocator_top_test;
    import cpba_pkg::*;

    localparam int MAP_PAGES    = MAP_PAGES_DEF;
    localparam int RANDOM_REQS  = 800;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int DRAIN_CYCLES = 80;
    localparam int HOLD_CYCLES  = 500;

    typedef struct {
        bit                 tracked;
        logic [COUNT_W-1:0] count;
    } issued_t;

    typedef struct {
        int first;
        int count;
    } run_t;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    logic                mode;
    logic [START_W-1:0]  start_page;
    logic [COUNT_W-1:0]  page_count;
    logic                rsp_valid;
    logic                rsp_stall;
    logic [STATUS_W-1:0] status;
    logic [BASE_W-1:0]   base_page;
    int                  error_count;
    int                  pending_results;

    issued_t             in_flight[$];
    run_t                live_runs[$];
    int                  live_pages = 0;
    int                  reqs_sent = 0;
    int                  directed_reqs = 0;
    int                  results_by_status[4] = '{0, 0, 0, 0};

    contiguous_page_bitmap_allocator_top #(
        .MAP_PAGES(MAP_PAGES)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .mode       (mode),
        .start_page (start_page),
        .page_count (page_count),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .status     (status),
        .base_page  (base_page)
    );

    cpba_result_checker #(
        .MAP_PAGES(MAP_PAGES)
    ) u_result_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .mode            (mode),
        .start_page      (start_page),
        .page_count      (page_count),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .status          (status),
        .base_page       (base_page),
        .error_count     (error_count),
        .pending_results (pending_results)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        int cycles_run;
        cycles_run = 0;
        while (cycles_run < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles_run++;
        end
        $display("timeout after %0d cycles", cycles_run);
        $display("DONE: errors detected");
        $finish;
    end

    // result side stall pattern, with one long hold-off under load
    initial
    begin
        int  phase_len;
        int  style;
        bit  held_off;
        held_off = 1'b0;
        forever
        begin
            if (!held_off && reqs_sent >= 120)
            begin
                // block backs up and stalls its request side
                held_off = 1'b1;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                style     = $urandom_range(3);
                phase_len = $urandom_range(200, 20);
                repeat (phase_len)
                begin
                    case (style)
                        0:       rsp_stall <= 1'b0;
                        1:       rsp_stall <= ($urandom_range(3) == 0);
                        2:       rsp_stall <= ($urandom_range(4) != 0);
                        default: rsp_stall <= ($urandom_range(1) == 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // record runs the block handed out so later frees can target them
    always @(posedge clk)
    begin
        issued_t done_req;
        if (rst_n && rsp_valid && !rsp_stall && in_flight.size() > 0)
        begin
            done_req = in_flight.pop_front();
            results_by_status[status]++;
            if (done_req.tracked && status == ST_OK)
            begin
                live_runs.push_back('{int'(base_page), int'(done_req.count)});
                live_pages += int'(done_req.count);
            end
        end
    end

    // present one request beat and hold it until accepted
    task automatic offer(
        input logic               req_mode,
        input logic [START_W-1:0] first,
        input logic [COUNT_W-1:0] count,
        input bit                 tracked
    );
        req_valid  <= 1'b1;
        mode       <= req_mode;
        start_page <= first;
        page_count <= count;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        in_flight.push_back('{tracked, count});
        reqs_sent++;
    endtask

    // random request: mostly allocs and frees of live runs, some noise
    task automatic make_random_request(
        output logic               req_mode,
        output logic [START_W-1:0] first,
        output logic [COUNT_W-1:0] count,
        output bit                 tracked
    );
        int   roll;
        int   idx;
        int   cut;
        run_t r;
        roll     = $urandom_range(99);
        tracked  = 1'b0;
        req_mode = MODE_ALLOC;
        first    = START_W'($urandom);
        count    = '0;
        if (roll < 12)
        begin
            // any field value at all
            req_mode = ($urandom_range(1) == 0) ? MODE_ALLOC : MODE_FREE;
            count    = COUNT_W'($urandom);
        end
        else if (roll < 18 && live_runs.size() > 0)
        begin
            // live run stretched by one page
            idx      = $urandom_range(live_runs.size() - 1);
            r        = live_runs[idx];
            req_mode = MODE_FREE;
            first    = (($urandom_range(1) == 1) && r.first > 0) ? START_W'(r.first - 1)
                                                                 : START_W'(r.first);
            count    = COUNT_W'(r.count + 1);
        end
        else if (live_runs.size() > 0 && (roll < 55 || live_pages > 700))
        begin
            idx      = $urandom_range(live_runs.size() - 1);
            r        = live_runs[idx];
            req_mode = MODE_FREE;
            first    = START_W'(r.first);
            if (r.count > 1 && $urandom_range(3) == 0)
            begin
                // release the head, keep the tail live
                cut = $urandom_range(r.count - 1, 1);
                count = COUNT_W'(cut);
                live_runs[idx].first = r.first + cut;
                live_runs[idx].count = r.count - cut;
            end
            else
            begin
                count = COUNT_W'(r.count);
                live_runs.delete(idx);
            end
            live_pages -= int'(count);
        end
        else
        begin
            // allocate, mostly small runs
            tracked = 1'b1;
            roll    = $urandom_range(99);
            if (roll < 65)
                count = COUNT_W'($urandom_range(8, 1));
            else if (roll < 88)
                count = COUNT_W'($urandom_range(64, 9));
            else if (roll < 97)
                count = COUNT_W'($urandom_range(400, 65));
            else
                count = COUNT_W'($urandom_range(2047, 401));
        end
    endtask

    // stimulus and verdict
    initial
    begin
        logic               req_mode;
        logic [START_W-1:0] first;
        logic [COUNT_W-1:0] count;
        bit                 tracked;
        int                 burst_left;
        int                 gap;
        int                 n;

        req_valid  <= 1'b0;
        mode       <= MODE_ALLOC;
        start_page <= '0;
        page_count <= '0;
        rst_n      <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // zero count in both modes
        offer(MODE_ALLOC, 10'd0,    11'd0,    1'b0);
        offer(MODE_FREE,  10'd1023, 11'd0,    1'b0);
        // page zero is reserved, so the first page handed out is one
        offer(MODE_ALLOC, 10'd0,    11'd1,    1'b0);
        // counts above what the map has free
        offer(MODE_ALLOC, 10'd0,    11'd2047, 1'b0);
        offer(MODE_ALLOC, 10'd0,    11'd1024, 1'b0);
        // free running past the end of the map, free of a free page
        offer(MODE_FREE,  10'd1023, 11'd2,    1'b0);
        offer(MODE_FREE,  10'd5,    11'd1,    1'b0);
        // release page zero and get it back
        offer(MODE_FREE,  10'd0,    11'd2,    1'b0);
        offer(MODE_ALLOC, 10'd0,    11'd1,    1'b0);
        // fill the map up to the last page
        offer(MODE_ALLOC, 10'd0,    11'd1022, 1'b0);
        offer(MODE_ALLOC, 10'd0,    11'd2,    1'b0);
        offer(MODE_ALLOC, 10'd0,    11'd1,    1'b0);
        offer(MODE_ALLOC, 10'd0,    11'd1,    1'b0);
        // whole map freed, taken in one run, freed again
        offer(MODE_FREE,  10'd0,    11'd1024, 1'b0);
        offer(MODE_ALLOC, 10'd0,    11'd1024, 1'b0);
        offer(MODE_FREE,  10'd512,  11'd1024, 1'b0);
        offer(MODE_FREE,  10'd0,    11'd1024, 1'b0);
        // scattered single holes too short for a run of two
        offer(MODE_ALLOC, 10'd0,    11'd1023, 1'b0);
        offer(MODE_FREE,  10'd1,    11'd1,    1'b0);
        offer(MODE_ALLOC, 10'd0,    11'd2,    1'b0);
        offer(MODE_FREE,  10'd0,    11'd1,    1'b0);
        offer(MODE_ALLOC, 10'd0,    11'd2,    1'b0);
        // leaves the map empty for the random part
        offer(MODE_FREE,  10'd0,    11'd1023, 1'b0);
        directed_reqs = reqs_sent;

        // random bursts with random gaps between them
        burst_left = 0;
        for (n = 0; n < RANDOM_REQS; n++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(40, 1);
                gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(80, 1);
                if (gap > 0)
                begin
                    req_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
            make_random_request(req_mode, first, count, tracked);
            offer(req_mode, first, count, tracked);
        end
        req_valid <= 1'b0;

        // drain
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d requests, %0d of them directed corner cases, with random idling",
                 reqs_sent, directed_reqs);
        $display("outcomes: %0d ok, %0d no room, %0d bad free, %0d zero count",
                 results_by_status[ST_OK], results_by_status[ST_NO_ROOM],
                 results_by_status[ST_BAD_FREE], results_by_status[ST_ZERO]);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
src/cpba_pkg.sv
src/cpba_map_ram.sv
src/contiguous_page_bitmap_allocator_top.sv
src/cpba_checker.sv
dv/cpba_result_checker.sv
dv/contiguous_page_bitmap_allocator_top_test.sv
